>>> rtl/cor_pkg.sv
// Shared constants and types for the circle octant rasterizer.
`timescale 1ns / 1ps

package cor_pkg;

    localparam int FRAME_BITS  = 13;
    localparam int COLOR_BITS  = 24;
    localparam int CFG_IDX_BITS = 1;
    localparam int OCT_BITS    = 3;

    localparam logic [FRAME_BITS-1:0] FRAME_RESET = 13'd4096;

    // operation codes
    localparam logic OP_START = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_HEIGHT = 1'b1;

    localparam logic [OCT_BITS-1:0] LAST_OCTANT = 3'd7;

    // decision value constants
    localparam int DEC_INIT      = 3;
    localparam int DEC_STEP_DOWN = 10;
    localparam int DEC_STEP_FLAT = 6;

    typedef struct packed {
        logic in_frame;
        logic last;
        logic done;
    } t_pix_flags;

endpackage

>>> rtl/cor_front.sv
// Front end: takes items, holds circle state, issues one step job per tick.
`timescale 1ns / 1ps

module cor_front #(
    parameter int COORD_BITS = 12,
    parameter int JOB_W      = 4 * COORD_BITS + cor_pkg::COLOR_BITS + 1
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  logic                          i_operation,
    input  logic [COORD_BITS-1:0]         i_center_x,
    input  logic [COORD_BITS-1:0]         i_center_y,
    input  logic [COORD_BITS-1:0]         i_radius,
    input  logic [cor_pkg::COLOR_BITS-1:0] i_draw_color,
    output logic                          o_job_push,
    output logic [JOB_W-1:0]              o_job,
    output logic                          o_active
);
    localparam int C = COORD_BITS;
    localparam int D = COORD_BITS + 4;

    logic [C-1:0]                   r_point_x, n_point_x;
    logic [C-1:0]                   r_point_y, n_point_y;
    logic signed [D-1:0]            r_dec, n_dec;
    logic [C-1:0]                   r_cx, r_cy;
    logic [cor_pkg::COLOR_BITS-1:0] r_color;
    logic                           r_active, n_active;

    logic signed [D-1:0] dx, dy, dec_down, dec_flat, dec_init;
    logic                d_gt;
    logic [C:0]          nx, ny;
    logic                step_done;
    logic                is_start, is_tick;

    assign is_start = i_accept && (i_operation == cor_pkg::OP_START);
    assign is_tick  = i_accept && (i_operation == cor_pkg::OP_TICK) && r_active;

    always_comb begin
        dx       = $signed(D'(r_point_x));
        dy       = $signed(D'(r_point_y));
        d_gt     = r_dec > $signed(D'(0));
        dec_down = r_dec + ((dx - dy) <<< 2) + $signed(D'(cor_pkg::DEC_STEP_DOWN));
        dec_flat = r_dec + (dx <<< 2) + $signed(D'(cor_pkg::DEC_STEP_FLAT));
        dec_init = $signed(D'(cor_pkg::DEC_INIT)) - ($signed(D'(i_radius)) <<< 1);
        nx        = {1'b0, r_point_x} + (C+1)'(1);
        ny        = {1'b0, r_point_y} - (C+1)'(d_gt);
        // y may drop to minus one on the last step, so compare signed
        step_done = $signed(ny) < $signed(nx);
    end

    always_comb begin
        n_point_x = r_point_x;
        n_point_y = r_point_y;
        n_dec     = r_dec;
        n_active  = r_active;
        if (is_start) begin
            n_point_x = '0;
            n_point_y = i_radius;
            n_dec     = dec_init;
            n_active  = 1'b1;
        end else if (is_tick) begin
            n_point_x = nx[C-1:0];
            n_point_y = ny[C-1:0];
            n_dec     = d_gt ? dec_down : dec_flat;
            n_active  = !step_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_point_x <= '0;
            r_point_y <= '0;
            r_dec     <= '0;
            r_cx      <= '0;
            r_cy      <= '0;
            r_color   <= '0;
            r_active  <= 1'b0;
        end else begin
            r_point_x <= n_point_x;
            r_point_y <= n_point_y;
            r_dec     <= n_dec;
            r_active  <= n_active;
            if (is_start) begin
                r_cx    <= i_center_x;
                r_cy    <= i_center_y;
                r_color <= i_draw_color;
            end
        end
    end

    assign o_job_push = is_tick;
    assign o_job      = {r_cx, r_cy, r_point_x, r_point_y, r_color, step_done};
    assign o_active   = r_active;

endmodule

>>> rtl/cor_fifo.sv
// Two-entry queue of step jobs between the front and back ends.
`timescale 1ns / 1ps

module cor_fifo #(
    parameter int WIDTH = 73
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);
    logic [WIDTH-1:0] r_mem [2];
    logic             r_wr, r_rd;
    logic [1:0]       r_count;

    logic do_push, do_pop;
    assign do_push = i_push && (r_count != 2'd2);
    assign do_pop  = i_pop && (r_count != 2'd0);

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (do_push) begin
                r_wr <= !r_wr;
            end
            if (do_pop) begin
                r_rd <= !r_rd;
            end
            r_count <= r_count + 2'(do_push) - 2'(do_pop);
        end
    end

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_mem[r_rd];

endmodule

>>> rtl/cor_back.sv
// Back end: walks the eight octants of a step job into the output register.
`timescale 1ns / 1ps

module cor_back #(
    parameter int COORD_BITS = 12,
    parameter int JOB_W      = 4 * COORD_BITS + cor_pkg::COLOR_BITS + 1
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [cor_pkg::CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [cor_pkg::FRAME_BITS-1:0]   i_cfg_wdata,
    input  logic                             i_job_valid,
    input  logic [JOB_W-1:0]                 i_job,
    output logic                             o_job_pop,
    input  logic                             i_pop,
    output logic                             o_valid,
    output logic signed [COORD_BITS+1:0]     o_pixel_x,
    output logic signed [COORD_BITS+1:0]     o_pixel_y,
    output logic [cor_pkg::COLOR_BITS-1:0]   o_pixel_color,
    output cor_pkg::t_pix_flags              o_flags
);
    localparam int C  = COORD_BITS;
    localparam int P  = COORD_BITS + 2;
    localparam int CW = (C + 1 > cor_pkg::FRAME_BITS) ? C + 1 : cor_pkg::FRAME_BITS;

    logic [cor_pkg::FRAME_BITS-1:0] r_fw, r_fh;

    logic [C-1:0]                   r_cx, r_cy, r_x, r_y;
    logic [cor_pkg::COLOR_BITS-1:0] r_color;
    logic                           r_done;
    logic                           r_busy;
    logic [cor_pkg::OCT_BITS-1:0]   r_oct;

    logic                           r_out_valid;
    logic signed [P-1:0]            r_px, r_py;
    logic [cor_pkg::COLOR_BITS-1:0] r_pcolor;
    cor_pkg::t_pix_flags            r_flags;

    logic                advance, at_last, load;
    logic [C-1:0]        a, b;
    logic signed [P-1:0] px, py;
    logic                in_x, in_y;
    cor_pkg::t_pix_flags n_flags;

    assign advance = r_busy && (!r_out_valid || i_pop);
    assign at_last = (r_oct == cor_pkg::LAST_OCTANT);
    assign load    = i_job_valid && (!r_busy || (advance && at_last));

    // bit 2 swaps x and y, bit 0 negates the column term, bit 1 the row term
    always_comb begin
        a  = r_oct[2] ? r_y : r_x;
        b  = r_oct[2] ? r_x : r_y;
        px = r_oct[0] ? $signed(P'(r_cx) - P'(a)) : $signed(P'(r_cx) + P'(a));
        py = r_oct[1] ? $signed(P'(r_cy) - P'(b)) : $signed(P'(r_cy) + P'(b));
        in_x = !px[P-1] && (CW'(px[C:0]) < CW'(r_fw));
        in_y = !py[P-1] && (CW'(py[C:0]) < CW'(r_fh));
        n_flags.in_frame = in_x && in_y;
        n_flags.last     = at_last;
        n_flags.done     = at_last && r_done;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fw <= cor_pkg::FRAME_RESET;
            r_fh <= cor_pkg::FRAME_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                cor_pkg::REG_FRAME_WIDTH:  r_fw <= i_cfg_wdata;
                cor_pkg::REG_FRAME_HEIGHT: r_fh <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_oct       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_busy <= 1'b1;
                r_oct  <= '0;
            end else if (advance) begin
                r_busy <= !at_last;
                r_oct  <= r_oct + cor_pkg::OCT_BITS'(1);
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            {r_cx, r_cy, r_x, r_y, r_color, r_done} <= i_job;
        end
        if (advance) begin
            r_px     <= px;
            r_py     <= py;
            r_pcolor <= r_color;
            r_flags  <= n_flags;
        end
    end

    assign o_job_pop     = load;
    assign o_valid       = r_out_valid;
    assign o_pixel_x     = r_px;
    assign o_pixel_y     = r_py;
    assign o_pixel_color = r_pcolor;
    assign o_flags       = r_flags;

endmodule

>>> rtl/circle_octant_rasterizer.sv
// Top level of the circle octant rasterizer.
`timescale 1ns / 1ps
// Midpoint circle rasterizer with eight-way symmetry.
// Input channel (push/full): a transfer happens on a clock edge with push high
// and full low. operation START latches centre, radius and colour and emits
// nothing; operation TICK emits the eight symmetric pixels of the current point
// and advances it. A tick with no circle active is taken and dropped.
// Result channel (empty/pop): the oldest pixel sits on the o_ ports while empty
// is low; a transfer happens on an edge with pop high and empty low.
// last_of_step marks the eighth pixel of a tick, circle_done the final one.
// With the block idle, the first pixel of a tick passes through the job queue,
// the octant sequencer load and the output register before it is visible.
// Throughput: one pixel per cycle unless the receiver stalls, set by the single
// result port the octant sequencer drives. A two-entry job queue between the
// front end and the octant sequencer lets new ticks be taken while pixels drain.
// When the receiver stalls the output register holds its pixel, the queue
// fills and full rises; nothing is lost.
// Reset (synchronous, active low) clears the circle state, empties the queue
// and the output register and sets both frame registers to 4096.
// Configuration: write enable, index 0 frame_width, 1 frame_height.

module circle_octant_rasterizer #(
    parameter int COORD_BITS = 12
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [cor_pkg::CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [cor_pkg::FRAME_BITS-1:0]   i_cfg_wdata,
    input  logic                             push,
    output logic                             full,
    input  logic                             i_operation,
    input  logic [COORD_BITS-1:0]            i_center_x,
    input  logic [COORD_BITS-1:0]            i_center_y,
    input  logic [COORD_BITS-1:0]            i_radius,
    input  logic [cor_pkg::COLOR_BITS-1:0]   i_draw_color,
    output logic                             empty,
    input  logic                             pop,
    output logic signed [COORD_BITS+1:0]     o_pixel_x,
    output logic signed [COORD_BITS+1:0]     o_pixel_y,
    output logic [cor_pkg::COLOR_BITS-1:0]   o_pixel_color,
    output logic                             o_inside_res,
    output logic                             o_last_of_step,
    output logic                             o_circle_done
);
    // job: centre x, centre y, point x, point y, colour, final-step flag
    localparam int JOB_W = 4 * COORD_BITS + cor_pkg::COLOR_BITS + 1;

    logic                w_job_push;
    logic                w_job_full;
    logic                w_job_valid;
    logic                w_job_pop;
    logic [JOB_W-1:0]    w_job_in, w_job_out;
    logic                w_accept;
    logic                w_active;
    logic                w_out_valid;
    cor_pkg::t_pix_flags w_flags;

    assign w_accept = push && !full;
    assign full     = w_job_full;

    // Front end: classify the transfer and update the circle state.
    cor_front #(
        .COORD_BITS (COORD_BITS),
        .JOB_W      (JOB_W)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (w_accept),
        .i_operation  (i_operation),
        .i_center_x   (i_center_x),
        .i_center_y   (i_center_y),
        .i_radius     (i_radius),
        .i_draw_color (i_draw_color),
        .o_job_push   (w_job_push),
        .o_job        (w_job_in),
        .o_active     (w_active)
    );

    // Job queue: decouple tick intake from pixel drain.
    cor_fifo #(
        .WIDTH (JOB_W)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_job_push),
        .i_data  (w_job_in),
        .i_pop   (w_job_pop),
        .o_full  (w_job_full),
        .o_valid (w_job_valid),
        .o_data  (w_job_out)
    );

    // Back end: step through the octants and hold each pixel for the receiver.
    cor_back #(
        .COORD_BITS (COORD_BITS),
        .JOB_W      (JOB_W)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_job_valid   (w_job_valid),
        .i_job         (w_job_out),
        .o_job_pop     (w_job_pop),
        .i_pop         (pop),
        .o_valid       (w_out_valid),
        .o_pixel_x     (o_pixel_x),
        .o_pixel_y     (o_pixel_y),
        .o_pixel_color (o_pixel_color),
        .o_flags       (w_flags)
    );

    assign empty          = !w_out_valid;
    assign o_inside_res   = w_flags.in_frame;
    assign o_last_of_step = w_flags.last;
    assign o_circle_done  = w_flags.done;

`ifndef SYNTHESIS
    // a job is never pushed into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_job_push && w_job_full))
        else $error("job pushed into full queue");

    // circle done only ever rides on the last pixel of a step
    a_done_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_circle_done) |-> o_last_of_step)
        else $error("circle_done without last_of_step");

    // a start transfer always leaves a circle active
    a_start_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_operation == cor_pkg::OP_START) |=> w_active)
        else $error("start did not activate circle");
`endif

endmodule

>>> sim/circle_pixel_checker.sv
// Checker that predicts and compares the pixel stream of the circle octant rasterizer.
`timescale 1ns / 1ps

module circle_pixel_checker #(
    parameter int COORD_BITS = 12
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [cor_pkg::CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [cor_pkg::FRAME_BITS-1:0]   i_cfg_wdata,
    input  logic                             i_push,
    input  logic                             i_full,
    input  logic                             i_operation,
    input  logic [COORD_BITS-1:0]            i_center_x,
    input  logic [COORD_BITS-1:0]            i_center_y,
    input  logic [COORD_BITS-1:0]            i_radius,
    input  logic [cor_pkg::COLOR_BITS-1:0]   i_draw_color,
    input  logic                             i_empty,
    input  logic                             i_pop,
    input  logic signed [COORD_BITS+1:0]     i_pixel_x,
    input  logic signed [COORD_BITS+1:0]     i_pixel_y,
    input  logic [cor_pkg::COLOR_BITS-1:0]   i_pixel_color,
    input  logic                             i_inside_res,
    input  logic                             i_last_of_step,
    input  logic                             i_circle_done,
    output int                               o_error_count,
    output int                               o_pixels_owed
);
    localparam int PIX_BITS = COORD_BITS + 2;
    localparam int DEC_BITS = COORD_BITS + 4;

    typedef struct packed {
        logic signed [PIX_BITS-1:0]     x;
        logic signed [PIX_BITS-1:0]     y;
        logic [cor_pkg::COLOR_BITS-1:0] color;
        logic                           in_frame;
        logic                           last;
        logic                           done;
    } t_pixel;

    t_pixel                         owed_pixels[$];
    t_pixel                         want;
    t_pixel                         got;
    logic [cor_pkg::FRAME_BITS-1:0] frame_w;
    logic [cor_pkg::FRAME_BITS-1:0] frame_h;
    logic [COORD_BITS-1:0]          pt_x;
    logic [COORD_BITS-1:0]          pt_y;
    logic [COORD_BITS-1:0]          ctr_x;
    logic [COORD_BITS-1:0]          ctr_y;
    logic signed [DEC_BITS-1:0]     dec;
    logic [cor_pkg::COLOR_BITS-1:0] pen_color;
    logic                           drawing;
    int                             errors = 0;

    assign o_error_count = errors;

    function automatic t_pixel make_pixel(int px, int py, logic last, logic fin);
        t_pixel p;
        p.x        = PIX_BITS'(px);
        p.y        = PIX_BITS'(py);
        p.color    = pen_color;
        p.in_frame = (px >= 0) && (py >= 0) && (px < int'(frame_w)) &&
                     (py < int'(frame_h));
        p.last     = last;
        p.done     = fin;
        return p;
    endfunction

    // Queue the eight mirrored pixels of the current point, then advance it.
    task automatic trace_step();
        int   cx;
        int   cy;
        int   x;
        int   y;
        int   nx;
        int   ny;
        int   nd;
        logic fin;
        cx = int'(ctr_x);
        cy = int'(ctr_y);
        x  = int'(pt_x);
        y  = int'(pt_y);
        if (dec > 0) begin
            nd = int'(dec) + 4 * (x - y) + cor_pkg::DEC_STEP_DOWN;
            ny = y - 1;
        end else begin
            nd = int'(dec) + 4 * x + cor_pkg::DEC_STEP_FLAT;
            ny = y;
        end
        nx  = x + 1;
        fin = (ny < nx);
        owed_pixels.push_back(make_pixel(cx + x, cy + y, 1'b0, 1'b0));
        owed_pixels.push_back(make_pixel(cx - x, cy + y, 1'b0, 1'b0));
        owed_pixels.push_back(make_pixel(cx + x, cy - y, 1'b0, 1'b0));
        owed_pixels.push_back(make_pixel(cx - x, cy - y, 1'b0, 1'b0));
        owed_pixels.push_back(make_pixel(cx + y, cy + x, 1'b0, 1'b0));
        owed_pixels.push_back(make_pixel(cx - y, cy + x, 1'b0, 1'b0));
        owed_pixels.push_back(make_pixel(cx + y, cy - x, 1'b0, 1'b0));
        owed_pixels.push_back(make_pixel(cx - y, cy - x, 1'b1, fin));
        pt_x    = COORD_BITS'(nx);
        pt_y    = COORD_BITS'(ny);
        dec     = DEC_BITS'(nd);
        drawing = !fin;
    endtask

    task automatic flag_pixel(string what, t_pixel exp_px, t_pixel act_px);
        errors++;
        if (errors <= 10) begin
            $display("%s: expected x=%0d y=%0d color=%06h in=%0b last=%0b done=%0b",
                     what, exp_px.x, exp_px.y, exp_px.color, exp_px.in_frame,
                     exp_px.last, exp_px.done);
            $display("    got x=%0d y=%0d color=%06h in=%0b last=%0b done=%0b",
                     act_px.x, act_px.y, act_px.color, act_px.in_frame,
                     act_px.last, act_px.done);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            owed_pixels.delete();
            frame_w   = cor_pkg::FRAME_RESET;
            frame_h   = cor_pkg::FRAME_RESET;
            pt_x      = '0;
            pt_y      = '0;
            ctr_x     = '0;
            ctr_y     = '0;
            dec       = '0;
            pen_color = '0;
            drawing   = 1'b0;
        end else begin
            // Retire the outgoing pixel before queuing new ones from this edge.
            if (i_pop && !i_empty) begin
                got.x        = i_pixel_x;
                got.y        = i_pixel_y;
                got.color    = i_pixel_color;
                got.in_frame = i_inside_res;
                got.last     = i_last_of_step;
                got.done     = i_circle_done;
                if (owed_pixels.size() == 0) begin
                    flag_pixel("pixel with none owed", '0, got);
                end else begin
                    want = owed_pixels.pop_front();
                    if (want !== got) begin
                        flag_pixel("pixel mismatch", want, got);
                    end
                end
            end
            if (i_cfg_we) begin
                if (i_cfg_index == cor_pkg::REG_FRAME_WIDTH) begin
                    frame_w = i_cfg_wdata;
                end else if (i_cfg_index == cor_pkg::REG_FRAME_HEIGHT) begin
                    frame_h = i_cfg_wdata;
                end
            end
            if (i_push && !i_full) begin
                if (i_operation == cor_pkg::OP_START) begin
                    ctr_x     = i_center_x;
                    ctr_y     = i_center_y;
                    pen_color = i_draw_color;
                    pt_x      = '0;
                    pt_y      = i_radius;
                    dec       = DEC_BITS'(cor_pkg::DEC_INIT - 2 * int'(i_radius));
                    drawing   = 1'b1;
                end else if (drawing) begin
                    trace_step();
                end
            end
        end
        o_pixels_owed <= owed_pixels.size();
    end

endmodule

>>> sim/tb_circle_octant_rasterizer.sv
// Testbench top for the circle octant rasterizer: stimulus, clock, reset and verdict.
`timescale 1ns / 1ps

module tb_circle_octant_rasterizer;

    localparam int COORD_BITS = 12;

    // Clock and reset; every block input starts at a known value.
    logic                             i_clk        = 1'b0;
    logic                             i_rst_n      = 1'b0;
    logic                             i_cfg_we     = 1'b0;
    logic [cor_pkg::CFG_IDX_BITS-1:0] i_cfg_index  = cor_pkg::REG_FRAME_WIDTH;
    logic [cor_pkg::FRAME_BITS-1:0]   i_cfg_wdata  = '0;
    logic                             push         = 1'b0;
    logic                             full;
    logic                             i_operation  = cor_pkg::OP_START;
    logic [COORD_BITS-1:0]            i_center_x   = '0;
    logic [COORD_BITS-1:0]            i_center_y   = '0;
    logic [COORD_BITS-1:0]            i_radius     = '0;
    logic [cor_pkg::COLOR_BITS-1:0]   i_draw_color = '0;
    logic                             empty;
    logic                             pop          = 1'b0;

    logic signed [COORD_BITS+1:0]   o_pixel_x;
    logic signed [COORD_BITS+1:0]   o_pixel_y;
    logic [cor_pkg::COLOR_BITS-1:0] o_pixel_color;
    logic                           o_inside_res;
    logic                           o_last_of_step;
    logic                           o_circle_done;

    int   error_count;
    int   pixels_owed;
    int   sent_items = 0;
    logic send_burst = 1'b0;   // sender runs back to back while set
    logic rx_burst   = 1'b0;   // receiver pops every cycle while set
    int   rx_wait    = 0;
    int   rx_gap;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    circle_octant_rasterizer #(
        .COORD_BITS(COORD_BITS)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .push          (push),
        .full          (full),
        .i_operation   (i_operation),
        .i_center_x    (i_center_x),
        .i_center_y    (i_center_y),
        .i_radius      (i_radius),
        .i_draw_color  (i_draw_color),
        .empty         (empty),
        .pop           (pop),
        .o_pixel_x     (o_pixel_x),
        .o_pixel_y     (o_pixel_y),
        .o_pixel_color (o_pixel_color),
        .o_inside_res  (o_inside_res),
        .o_last_of_step(o_last_of_step),
        .o_circle_done (o_circle_done)
    );

    circle_pixel_checker #(
        .COORD_BITS(COORD_BITS)
    ) pixel_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_push        (push),
        .i_full        (full),
        .i_operation   (i_operation),
        .i_center_x    (i_center_x),
        .i_center_y    (i_center_y),
        .i_radius      (i_radius),
        .i_draw_color  (i_draw_color),
        .i_empty       (empty),
        .i_pop         (pop),
        .i_pixel_x     (o_pixel_x),
        .i_pixel_y     (o_pixel_y),
        .i_pixel_color (o_pixel_color),
        .i_inside_res  (o_inside_res),
        .i_last_of_step(o_last_of_step),
        .i_circle_done (o_circle_done),
        .o_error_count (error_count),
        .o_pixels_owed (pixels_owed)
    );

    // Receiver: hold pop high, and after each transfer drop it for a randomly drawn
    // wait, which may be zero. Now and then flip into a no-stall stretch.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop     <= 1'b0;
            rx_wait <= 0;
        end else if (pop) begin
            if (!empty) begin
                if ($urandom_range(0, 31) == 0) rx_burst = !rx_burst;
                rx_gap = rx_burst ? 0 : $urandom_range(0, 6);
                if (rx_gap != 0) begin
                    pop     <= 1'b0;
                    rx_wait <= rx_gap;
                end
            end
        end else if (rx_wait > 1) begin
            rx_wait <= rx_wait - 1;
        end else begin
            pop     <= 1'b1;
            rx_wait <= 0;
        end
    end

    // Present one item and hold it until the transfer edge. push is left high
    // on return so a back-to-back item never drops and raises it in one step;
    // anything that pauses the sender lowers it first.
    task automatic send_item(logic op, logic [COORD_BITS-1:0] cx, logic [COORD_BITS-1:0] cy,
                             logic [COORD_BITS-1:0] r, logic [cor_pkg::COLOR_BITS-1:0] col);
        int gap;
        gap = send_burst ? 0 : $urandom_range(0, 6);
        if (gap != 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push         <= 1'b1;
        i_operation  <= op;
        i_center_x   <= cx;
        i_center_y   <= cy;
        i_radius     <= r;
        i_draw_color <= col;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        sent_items++;
    endtask

    // Ticks carry random junk in the start-only fields; the block must ignore it.
    task automatic tick_n(int count);
        repeat (count) begin
            send_item(cor_pkg::OP_TICK, COORD_BITS'($urandom), COORD_BITS'($urandom),
                      COORD_BITS'($urandom), cor_pkg::COLOR_BITS'($urandom));
        end
    endtask

    // Hold the sender until every owed pixel has come out, then let the
    // pipeline flush anything a dropped tick might still be carrying.
    task automatic settle();
        push <= 1'b0;
        do @(posedge i_clk); while (pixels_owed != 0);
        repeat (12) @(posedge i_clk);
    endtask

    // Frame registers change only with the block idle.
    task automatic set_frame(logic [cor_pkg::FRAME_BITS-1:0] w,
                             logic [cor_pkg::FRAME_BITS-1:0] h);
        settle();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= cor_pkg::REG_FRAME_WIDTH;
        i_cfg_wdata <= w;
        @(posedge i_clk);
        i_cfg_index <= cor_pkg::REG_FRAME_HEIGHT;
        i_cfg_wdata <= h;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // Centres near the origin and near the far edge make the inside flag flip.
    function automatic logic [COORD_BITS-1:0] pick_coord();
        case ($urandom_range(0, 2))
            0: return COORD_BITS'($urandom);
            1: return COORD_BITS'($urandom_range(0, 48));
            default: return COORD_BITS'($urandom_range(4070, 4095));
        endcase
    endfunction

    // Mostly whole small circles with random content; the rest is stray
    // ticks and circles cut short by a fresh start.
    task automatic run_batch(int quota);
        int target;
        int kind;
        int r;
        target = sent_items + quota;
        while (sent_items < target) begin
            send_burst = ($urandom_range(0, 4) == 0);
            kind       = $urandom_range(0, 9);
            if (kind == 0) begin
                tick_n($urandom_range(1, 3));
            end else if (kind == 1) begin
                send_item(cor_pkg::OP_START, COORD_BITS'($urandom), COORD_BITS'($urandom),
                          COORD_BITS'($urandom), cor_pkg::COLOR_BITS'($urandom));
                tick_n($urandom_range(0, 5));
            end else begin
                r = $urandom_range(0, 20);
                send_item(cor_pkg::OP_START, pick_coord(), pick_coord(), COORD_BITS'(r),
                          cor_pkg::COLOR_BITS'($urandom));
                // Enough ticks to finish the circle, plus at least one that is dropped.
                tick_n(r - r / 4 + 2);
            end
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part at the reset frame size.
        tick_n(1);                                          // no circle yet: dropped
        send_item(cor_pkg::OP_START, '0, '0, '0, '0);       // radius zero at the origin
        tick_n(2);                                          // one step, then a dropped tick
        send_item(cor_pkg::OP_START, '1, '1, '1, '1);       // all-ones centre and radius
        tick_n(3);
        send_item(cor_pkg::OP_START, '0, '0, '1, 24'h5A5A5A);   // abandon, pixels go negative
        tick_n(2);
        send_item(cor_pkg::OP_START, 12'd100, 12'd200, 12'd1, 24'hA5A5A5);
        tick_n(2);
        send_item(cor_pkg::OP_START, 12'd2048, 12'd2048, 12'd3, 24'h123456);  // hits x == y
        tick_n(4);

        // Random phases, each behind a frame change with the block drained.
        set_frame(13'd1, 13'd1);
        run_batch(18);
        set_frame(13'd0, 13'h1FFF);
        run_batch(18);
        set_frame(13'd40, 13'd24);
        run_batch(18);
        set_frame(cor_pkg::FRAME_BITS'($urandom), cor_pkg::FRAME_BITS'($urandom));
        run_batch(18);
        set_frame(cor_pkg::FRAME_RESET, cor_pkg::FRAME_RESET);
        run_batch(12);

        settle();
        if (error_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // Hang guard, far beyond the slowest correct run.
    initial begin
        #2000000;
        $display("tb: failure");
        $finish;
    end

endmodule
